FILE: sv/fixed_block_pool_allocator_assert.svh
// Assertion macros shared by the block pool allocator checkers.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define FBPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/fbpa_pkg.sv
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 9;
  localparam int ELEM_W  = 16;
  localparam int ALIGN_W = 13;
  localparam int AEXP_W  = 4;
  localparam int BS_W    = 17;           // element size rounded up to 4096
  localparam int SPAN_W  = BS_W + CNT_W; // block size times block count
  localparam int REGI_W  = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // register indexes
  localparam logic [REGI_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [REGI_W-1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [REGI_W-1:0] REG_ELEM_BYTES  = 2'd2;
  localparam logic [REGI_W-1:0] REG_ALIGN_BYTES = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = 32'd0;
  localparam logic [CNT_W-1:0]   RST_BLOCK_COUNT = 9'd256;
  localparam logic [ELEM_W-1:0]  RST_ELEM_BYTES  = 16'd4;
  localparam logic [ALIGN_W-1:0] RST_ALIGN_BYTES = 13'd4;

  typedef enum logic [2:0] {
    ST_INIT,   // link store rebuild sweep
    ST_IDLE,   // waiting for an input transfer
    ST_CHECK,  // range check, list head test, divider start
    ST_ALLOC,  // link read returns, pop the head
    ST_DIV,    // waiting for the block index
    ST_DONE    // result waits for the output register
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: sv/fbpa_if.sv
// Valid/ready channels carrying allocator requests and results.
interface fbpa_in_if import fbpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  logic              success;
  logic              in_pool;

  modport source (output valid, block_address, success, in_pool, input ready);
  modport sink   (input valid, block_address, success, in_pool, output ready);
endinterface

FILE: sv/fbpa_ram.sv
// Generic one-write one-read synchronous RAM with registered read data.
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fbpa_div.sv
// Restoring divider: one quotient bit per cycle, quotient width Q_W.
module fbpa_div import fbpa_pkg::*; #(
  parameter int Q_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SPAN_W-1:0] dividend,
  input  logic [BS_W-1:0]   divisor,
  output logic [Q_W-1:0]    quotient,
  output div_status_t       status
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dsh;
  logic [STEP_W-1:0] steps;
  logic              fits;

  assign fits = (rem >= dsh);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      steps  <= '0;
    end else begin
      status.done <= !start && status.busy && (steps == STEP_W'(1));
      if (start) begin
        status.busy <= 1'b1;
        steps       <= STEP_W'(Q_W);
      end else if (status.busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

  // datapath: trial subtract against the shifted divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= SPAN_W'(divisor) << (Q_W - 1);
      quotient <= '0;
    end else if (status.busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= Q_W'({quotient, fits});
    end
  end

endmodule

FILE: sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list of equal blocks held in a link RAM.
//
// One request at a time. An allocate passes from input transfer to result through range
// check and list head test with the link RAM read, pop, and the output register. A free of
// an address in the pool waits on the restoring divider, which turns the byte offset
// into a block index one bit per cycle; any other free goes straight to the result.
// A new request is taken as soon as the previous result sits in the output register.
// After reset and after every configuration write the link RAM is rebuilt in a sweep
// over all POOL_BLOCKS entries, during which no request is taken; register writes
// are taken throughout.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int POOL_BLOCKS = 256
) (
  input  logic               clk,
  input  logic               rst,
  fbpa_in_if.sink            in_ch,
  fbpa_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(POOL_BLOCKS);
  localparam int LINK_W = $clog2(POOL_BLOCKS + 1);
  localparam int Q_W    = (IDX_W < CNT_W) ? IDX_W : CNT_W;
  localparam int CMP_W  = (LINK_W > CNT_W) ? LINK_W : CNT_W;

  // configuration registers
  logic [ADDR_W-1:0]  pool_base;
  logic [CNT_W-1:0]   block_count;
  logic [ELEM_W-1:0]  element_bytes;
  logic [ALIGN_W-1:0] align_bytes;
  logic               cfg_we;
  logic [REGI_W-1:0]  cfg_idx;

  // derived pool geometry
  logic [AEXP_W-1:0]  align_exp;
  logic [BS_W-1:0]    align_mask;
  logic [BS_W-1:0]    bsize;
  logic [CNT_W-1:0]   eff_cnt;
  logic [SPAN_W-1:0]  span;
  logic [ADDR_W:0]    pool_end;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   sweep_idx;
  logic [LINK_W-1:0]  head;
  logic               req_cmd;
  logic [ADDR_W-1:0]  req_addr;
  logic [ADDR_W-1:0]  offset;
  logic               in_range;
  logic               head_ok;
  logic [SPAN_W-1:0]  prod;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_ok;
  logic               res_in_pool;
  logic               out_valid;
  logic               out_load;

  // link RAM and divider hookup
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;
  logic               div_start;
  logic [Q_W-1:0]     div_q;
  div_status_t        div_stat;
  logic               free_hit;

  // APB write decode
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base     <= RST_POOL_BASE;
      block_count   <= RST_BLOCK_COUNT;
      element_bytes <= RST_ELEM_BYTES;
      align_bytes   <= RST_ALIGN_BYTES;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_POOL_BASE:   pool_base     <= pwdata[ADDR_W-1:0];
        REG_BLOCK_COUNT: block_count   <= pwdata[CNT_W-1:0];
        REG_ELEM_BYTES:  element_bytes <= pwdata[ELEM_W-1:0];
        REG_ALIGN_BYTES: align_bytes   <= pwdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_POOL_BASE:   prdata = pool_base;
      REG_BLOCK_COUNT: prdata = PDATA_W'(block_count);
      REG_ELEM_BYTES:  prdata = PDATA_W'(element_bytes);
      REG_ALIGN_BYTES: prdata = PDATA_W'(align_bytes);
      default:         prdata = '0;
    endcase
  end

  // alignment: highest set bit, zero taken as one
  always_comb begin
    align_exp = '0;
    for (int i = 0; i < ALIGN_W; i++) begin
      if (align_bytes[i]) begin
        align_exp = AEXP_W'(i);
      end
    end
    align_mask = (BS_W'(1) << align_exp) - BS_W'(1);
  end

  // geometry pipeline, settles well within the rebuild sweep
  always_ff @(posedge clk) begin
    bsize    <= (BS_W'(element_bytes) + align_mask) & ~align_mask;
    eff_cnt  <= (CMP_W'(block_count) > CMP_W'(POOL_BLOCKS)) ? CNT_W'(POOL_BLOCKS)
                                                            : block_count;
    span     <= SPAN_W'(bsize) * SPAN_W'(eff_cnt);
    pool_end <= {1'b0, pool_base} + (ADDR_W + 1)'(span);
  end

  // request checks
  assign offset   = req_addr - pool_base;
  assign in_range = ({1'b0, req_addr} >= {1'b0, pool_base})
                 && ({1'b0, req_addr} < pool_end);
  assign head_ok  = CMP_W'(head) < CMP_W'(eff_cnt);
  assign free_hit = CNT_W'(div_q) < eff_cnt;

  assign in_ch.ready = (state == ST_IDLE);
  assign out_load    = (state == ST_DONE) && (!out_valid || out_ch.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else if (cfg_we) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state, RAM and divider controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = sweep_idx;
    ram_wdata  = LINK_W'(sweep_idx) + LINK_W'(1);
    div_start  = 1'b0;
    case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (sweep_idx == IDX_W'(POOL_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (req_cmd == CMD_ALLOC) begin
          state_next = head_ok ? ST_ALLOC : ST_DONE;
        end else if (in_range && (bsize != '0)) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ALLOC: begin
        state_next = ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we     = free_hit;
          ram_waddr  = IDX_W'(div_q);
          ram_wdata  = head;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // sweep counter and list head
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      sweep_idx <= '0;
      head      <= '0;
    end else begin
      if (state == ST_INIT) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end
      if (state == ST_ALLOC) begin
        head <= ram_rdata;
      end else if ((state == ST_DIV) && div_stat.done && free_hit) begin
        head <= LINK_W'(div_q);
      end
    end
  end

  // request capture and result build
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_cmd  <= in_ch.cmd;
      req_addr <= in_ch.address;
    end
    case (state)
      ST_CHECK: begin
        prod        <= SPAN_W'(head[Q_W-1:0]) * SPAN_W'(bsize);
        res_addr    <= '0;
        res_ok      <= 1'b0;
        res_in_pool <= in_range;
      end
      ST_ALLOC: begin
        res_addr <= pool_base + ADDR_W'(prod);
        res_ok   <= 1'b1;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_ok <= free_hit;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.block_address <= res_addr;
      out_ch.success       <= res_ok;
      out_ch.in_pool       <= res_in_pool;
    end
  end

  assign out_ch.valid = out_valid;

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fbpa_div #(
    .Q_W (Q_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset[SPAN_W-1:0]),
    .divisor  (bsize),
    .quotient (div_q),
    .status   (div_stat)
  );

endmodule

FILE: sv/fbpa_checker.sv
// Port-level checker for the block pool allocator and its bind.
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker import fbpa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_block_address,
  input logic              out_success,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              pready
);

  // a result waits until taken
  `FBPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  // only a granted result carries a nonzero address
  `FBPA_ASSERT_IMP(a_addr_grant, out_valid && (out_block_address != '0), out_success, "address without grant")
  // one request at a time
  `FBPA_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready, "request taken while busy")
  // a register write starts the rebuild sweep
  `FBPA_ASSERT_NXT(a_cfg_sweep, psel && penable && pwrite && pready, !in_ready, "request taken during rebuild")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_block_address (out_ch.block_address),
  .out_success       (out_ch.success),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .pready            (pready)
);

FILE: dv/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator: directed table, then random phases.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int POOL_BLOCKS  = 256;
  localparam int HALF_PERIOD  = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_PCT     = 6;
  localparam int MAX_PRINTS   = 100;
  localparam int N_DIRECTED   = 31;
  localparam int N_PHASES     = 8;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              success;
    logic              in_pool;
  } reply_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // one line of the directed table: a register write or a request
  typedef struct packed {
    row_kind_t         kind;
    logic [REGI_W-1:0] reg_idx;
    logic [31:0]       value;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic              typed;   // reply below is the one to expect
    reply_t            reply;
  } step_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fbpa_in_if  alloc_req ();
  fbpa_out_if alloc_rsp ();

  fixed_block_pool_allocator #(
    .POOL_BLOCKS(POOL_BLOCKS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (alloc_req),
    .out_ch  (alloc_rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow of the pool registers and free list
  logic [ADDR_W-1:0]  pool_base_sh;
  logic [CNT_W-1:0]   block_count_sh;
  logic [ELEM_W-1:0]  elem_bytes_sh;
  logic [ALIGN_W-1:0] align_bytes_sh;
  logic [CNT_W-1:0]   free_head;
  logic [CNT_W-1:0]   free_link [POOL_BLOCKS];

  reply_t            pending_replies [$];
  logic [ADDR_W-1:0] granted_blocks [$];   // handed out and not yet given back

  bit calm;   // no idling on either side
  int cycle_count;
  int n_errors;
  int n_requests;
  int n_checked;
  int n_grants;
  int n_refusals;
  int n_returns;
  int n_writes;

  step_t directed_steps [N_DIRECTED] = '{
    // after reset: base 0, 256 blocks of 4 bytes, pool is [0, 1024)
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'h0000_0000, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'hFFFF_FFFF, 1'b1,
      '{32'd4, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'h0000_0000, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd1023, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    // pool end itself is outside
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd1024, 1'b1,
      '{32'd0, 1'b0, 1'b0}},
    // misaligned free of the last block
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd1023, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b1,
      '{32'd1020, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd6, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    // double free of block 1 links it to itself
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd5, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    // empty pool
    '{ROW_WRITE, REG_BLOCK_COUNT, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b1,
      '{32'd0, 1'b0, 1'b0}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd0, 1'b1,
      '{32'd0, 1'b0, 1'b0}},
    // count above the pool size saturates
    '{ROW_WRITE, REG_BLOCK_COUNT, 32'd511, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd1023, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd1024, 1'b1,
      '{32'd0, 1'b0, 1'b0}},
    // zero element size: nothing is in the pool, allocates still pop
    '{ROW_WRITE, REG_ELEM_BYTES, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b1,
      '{32'd0, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'd0, 1'b1,
      '{32'd0, 1'b0, 1'b0}},
    // widest element, zero alignment, pool running past 4 GiB
    '{ROW_WRITE, REG_ELEM_BYTES, 32'd65535, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_WRITE, REG_ALIGN_BYTES, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_WRITE, REG_POOL_BASE, 32'hFFFF_0000, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_0000, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'h0000_FFFE, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_FREE, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'd0, 1'b0, '0},
    // alignment that is not a power of two rounds down to 4
    '{ROW_WRITE, REG_ALIGN_BYTES, 32'd6, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_WRITE, REG_ELEM_BYTES, 32'd5, CMD_ALLOC, 32'd0, 1'b0, '0},
    '{ROW_ITEM, REG_POOL_BASE, 32'd0, CMD_ALLOC, 32'hFFFF_0008, 1'b1,
      '{32'hFFFF_0000, 1'b1, 1'b1}}
  };

  // free list back to 0, 1, ..., with block 0 at the head
  function automatic void rebuild_free_list();
    for (int i = 0; i < POOL_BLOCKS; i++) free_link[i] = CNT_W'(i + 1);
    free_head = '0;
    granted_blocks.delete();
  endfunction

  function automatic int unsigned live_blocks();
    return (block_count_sh > POOL_BLOCKS) ? POOL_BLOCKS : int'(block_count_sh);
  endfunction

  // element size rounded up to the top set bit of the alignment
  function automatic longint unsigned block_bytes();
    longint unsigned align_pow;
    int unsigned     v;
    align_pow = 1;
    v = 32'(align_bytes_sh);
    while (v > 1) begin
      v = v >> 1;
      align_pow = align_pow << 1;
    end
    return (64'(elem_bytes_sh) + align_pow - 1) & ~(align_pow - 1);
  endfunction

  function automatic longint unsigned pool_limit();
    return 64'(pool_base_sh) + block_bytes() * live_blocks();
  endfunction

  function automatic void apply_register(logic [REGI_W-1:0] idx, logic [31:0] value);
    case (idx)
      REG_POOL_BASE:   pool_base_sh   = value[ADDR_W-1:0];
      REG_BLOCK_COUNT: block_count_sh = value[CNT_W-1:0];
      REG_ELEM_BYTES:  elem_bytes_sh  = value[ELEM_W-1:0];
      REG_ALIGN_BYTES: align_bytes_sh = value[ALIGN_W-1:0];
      default: ;
    endcase
    rebuild_free_list();
  endfunction

  // result of one request, updating the shadow free list
  function automatic reply_t predict_pool_op(logic op, logic [ADDR_W-1:0] addr);
    reply_t          r;
    longint unsigned base;
    longint unsigned bsize;
    longint unsigned idx;
    int unsigned     n;
    n     = live_blocks();
    bsize = block_bytes();
    base  = 64'(pool_base_sh);
    r     = '0;
    r.in_pool = (64'(addr) >= base) && (64'(addr) < base + bsize * n);
    if (op == CMD_ALLOC) begin
      if (free_head < n) begin
        r.block_address = ADDR_W'(base + free_head * bsize);
        r.success       = 1'b1;
        free_head       = free_link[free_head];
        n_grants++;
      end else begin
        n_refusals++;
      end
    end else if (r.in_pool && bsize != 0) begin
      idx = (64'(addr) - base) / bsize;
      if (idx < n) begin
        free_link[idx] = free_head;
        free_head      = CNT_W'(idx);
        r.success      = 1'b1;
        n_returns++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // register write, only once every outstanding result is back
  task automatic write_register(logic [REGI_W-1:0] idx, logic [31:0] value);
    alloc_req.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, value);
    n_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one request transfer; valid stays up afterwards for the next one
  task automatic send_request(logic op, logic [ADDR_W-1:0] addr, logic typed, reply_t want);
    reply_t r;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      alloc_req.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    alloc_req.valid   = 1'b1;
    alloc_req.cmd     = op;
    alloc_req.address = addr;
    do @(posedge clk); while (!alloc_req.ready);
    r = predict_pool_op(op, addr);
    if (op == CMD_ALLOC && r.success) granted_blocks.push_back(r.block_address);
    pending_replies.push_back(typed ? want : r);
    n_requests++;
    @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] address_in_pool();
    longint unsigned span;
    span = block_bytes() * live_blocks();
    if (span == 0) return pool_base_sh;
    return ADDR_W'(64'(pool_base_sh) + ({$urandom, $urandom} % span));
  endfunction

  // mostly allocates and frees of granted blocks, some noise and boundaries
  task automatic random_request();
    int unsigned       pick;
    int unsigned       slot;
    logic              op;
    logic [ADDR_W-1:0] a;
    longint unsigned   bsize;
    bsize = block_bytes();
    pick  = $urandom_range(99);
    if (pick < 45) begin
      op = CMD_ALLOC;
      a  = $urandom_range(1) ? address_in_pool() : ADDR_W'($urandom);
    end else if (pick < 80 && granted_blocks.size() > 0) begin
      op   = CMD_FREE;
      slot = $urandom_range(granted_blocks.size() - 1);
      a    = granted_blocks[slot];
      granted_blocks.delete(slot);
      if (bsize != 0 && $urandom_range(3) == 0) a = a + ADDR_W'({$urandom, $urandom} % bsize);
    end else if (pick < 90) begin
      op = CMD_FREE;
      a  = address_in_pool();
    end else begin
      op = 1'($urandom_range(1));
      case ($urandom_range(5))
        0:       a = pool_base_sh;
        1:       a = pool_base_sh - 1;
        2:       a = ADDR_W'(pool_limit() - 1);
        3:       a = ADDR_W'(pool_limit());
        default: a = $urandom;
      endcase
    end
    send_request(op, a, 1'b0, '0);
  endtask

  task automatic run_phase(int items, logic [31:0] base, logic [31:0] count,
                           logic [31:0] elem, logic [31:0] align);
    write_register(REG_POOL_BASE, base);
    write_register(REG_BLOCK_COUNT, count);
    write_register(REG_ELEM_BYTES, elem);
    write_register(REG_ALIGN_BYTES, align);
    repeat (items) random_request();
  endtask

  // result side: random stalls, ready changes at the falling edge
  always @(negedge clk) begin
    alloc_rsp.ready = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && alloc_rsp.valid && alloc_rsp.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        n_checked++;
        if (alloc_rsp.block_address !== want.block_address)
          report_mismatch($sformatf("block_address %h, want %h",
                                    alloc_rsp.block_address, want.block_address));
        if (alloc_rsp.success !== want.success)
          report_mismatch($sformatf("success %b, want %b", alloc_rsp.success, want.success));
        if (alloc_rsp.in_pool !== want.in_pool)
          report_mismatch($sformatf("in_pool %b, want %b", alloc_rsp.in_pool, want.in_pool));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_replies.size());
      $display("fixed_block_pool_allocator test failed");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    calm              = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    alloc_req.valid   = 1'b0;
    alloc_req.cmd     = CMD_ALLOC;
    alloc_req.address = '0;
    alloc_rsp.ready   = 1'b0;
    pool_base_sh      = RST_POOL_BASE;
    block_count_sh    = RST_BLOCK_COUNT;
    elem_bytes_sh     = RST_ELEM_BYTES;
    align_bytes_sh    = RST_ALIGN_BYTES;
    rebuild_free_list();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_WRITE) begin
        write_register(directed_steps[i].reg_idx, directed_steps[i].value);
      end else begin
        send_request(directed_steps[i].cmd, directed_steps[i].addr,
                     directed_steps[i].typed, directed_steps[i].reply);
      end
    end

    // random phases over several register settings
    for (int p = 0; p < N_PHASES; p++) begin
      calm = (p == 4);
      case (p)
        0: run_phase(220, $urandom, 32'd256, 32'd4, 32'd4);
        1: run_phase(150, 32'd0, 32'd1, 32'd1, 32'd1);
        2: run_phase(180, $urandom, 32'd8, 32'd65535, 32'd4096);
        3: run_phase(120, 32'hFFFF_FFFF, 32'd256, 32'd4096, 32'd4096);
        4: run_phase(250, $urandom, $urandom_range(16, 1), $urandom_range(65535),
                     $urandom_range(8191));
        5: run_phase(40, $urandom, 32'd0, $urandom_range(65535), 32'h1FFF);
        6: run_phase(250, $urandom, $urandom_range(511, 257), $urandom_range(64, 1),
                     32'd1 << $urandom_range(12));
        default: run_phase(290, $urandom, $urandom, $urandom, $urandom);
      endcase
    end
    calm = 1'b0;
    alloc_req.valid = 1'b0;

    // let the last results drain
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d register writes: %0d grants, %0d refusals,",
             n_requests, n_writes, n_grants, n_refusals);
    $display("%0d blocks given back, %0d results compared, %0d mismatches.",
             n_returns, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("fixed_block_pool_allocator test passed");
    end else begin
      $display("fixed_block_pool_allocator test failed");
    end
    $finish;
  end

endmodule
